// ----- hw/rtl/dds_sine_triangle_square_generator_defines.svh -----
// Assertion macros shared by the DDS generator RTL.
// No dependencies; modules that assert take this file by include.
`ifndef DDS_SINE_TRIANGLE_SQUARE_GENERATOR_DEFINES_SVH
`define DDS_SINE_TRIANGLE_SQUARE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define DSG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsg: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define DSG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsg: next-cycle check failed");

`endif

// ----- hw/rtl/dsg_pkg.sv -----
// Package for the DDS generator: widths, register codes, config struct,
// and the quarter-wave sine table function. No dependencies.
package dsg_pkg;

   localparam int PHASE_BITS_DEF      = 32;
   localparam int LUT_ADDR_BITS_DEF   = 10;
   localparam int LUT_SAMPLE_BITS_DEF = 16;

   localparam int STEP_W    = 32;  // phase step register
   localparam int MV_W      = 13;  // amplitude / reference
   localparam int OUT_W     = 15;  // millivolt outputs, two's complement
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE  = 2'd2;

   typedef struct packed {
      logic [STEP_W-1:0] phase_step;
      logic [MV_W-1:0]   amplitude_mv;
      logic [MV_W-1:0]   reference_mv;
   } dsg_cfg_type;

   localparam dsg_cfg_type CFG_RESET = '{
      phase_step:   32'd4295,
      amplitude_mv: 13'd2500,
      reference_mv: 13'd2500
   };

   localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

   // One quarter-wave entry: round(sin(pi/2 * idx / 2^addr_bits) * smax),
   // Q30 Taylor series to x^17, each term truncated.
   function automatic logic [31:0] sine_entry(input int idx, input int addr_bits,
                                              input int sample_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        smax;
      logic signed [63:0] sum;
      smax = (64'd1 << (sample_bits - 1)) - 64'd1;
      x    = (HALF_PI_Q30 * 64'(idx) + (64'd1 << (addr_bits - 1))) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return 32'(((64'(sum) * smax) + (64'd1 << 29)) >> 30);
   endfunction

endpackage

// ----- hw/rtl/dsg_front.sv -----
// Front end: takes tick words and advances the phase accumulator.
// Depends on dsg_pkg; feeds dsg_queue.
`include "dds_sine_triangle_square_generator_defines.svh"

module dsg_front #(
   parameter int PHASE_BITS = dsg_pkg::PHASE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dsg_pkg::STEP_W-1:0]  phase_step,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_tick,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [PHASE_BITS-1:0]       push_phase
);
   import dsg_pkg::*;

   localparam int SUM_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [SUM_W-1:0]      phase_sum;
   logic                  accept;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // step lands at the low end; wraps modulo 2^PHASE_BITS
   assign phase_sum  = SUM_W'(phase_ff) + SUM_W'(phase_step);
   assign push_phase = req_tick ? phase_sum[PHASE_BITS-1:0] : phase_ff;
   assign phase_in   = accept ? push_phase : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   `DSG_ASSERT_NEXT(a_hold_phase_no_tick, accept && !req_tick, $stable(phase_ff))

endmodule

// ----- hw/rtl/dsg_queue.sv -----
// Short FIFO of phase words between front and back end.
// Depends on dsg_pkg for the depth.
`include "dds_sine_triangle_square_generator_defines.svh"

module dsg_queue #(
   parameter int WIDTH = dsg_pkg::PHASE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import dsg_pkg::*;

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   in_fire;
   logic                   out_fire;

   assign in_ready  = count_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = in_fire  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (in_fire && !out_fire) begin
         count_in = count_ff + 1'b1;
      end else if (out_fire && !in_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `DSG_ASSERT_NEXT(a_count_up, in_fire && !out_fire, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- hw/rtl/dsg_back.sv -----
// Back end: waveform pipeline, quarter-wave ROM, scaling and output register.
// Depends on dsg_pkg (config struct, sine_entry); fed by dsg_queue.
`include "dds_sine_triangle_square_generator_defines.svh"

module dsg_back #(
   parameter int PHASE_BITS      = dsg_pkg::PHASE_BITS_DEF,
   parameter int LUT_ADDR_BITS   = dsg_pkg::LUT_ADDR_BITS_DEF,
   parameter int LUT_SAMPLE_BITS = dsg_pkg::LUT_SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dsg_pkg::dsg_cfg_type               cfg,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  logic [PHASE_BITS-1:0]              pop_phase,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dsg_pkg::OUT_W-1:0]   rsp_sine_mv,
   output logic signed [dsg_pkg::OUT_W-1:0]   rsp_triangle_mv,
   output logic signed [dsg_pkg::OUT_W-1:0]   rsp_square_mv
);
   import dsg_pkg::*;

   localparam int SAMP_W  = LUT_SAMPLE_BITS - 1;
   localparam int ROM_AW  = LUT_ADDR_BITS + 1;
   localparam int ROM_LEN = (1 << LUT_ADDR_BITS) + 1;
   localparam int SMAX    = (1 << SAMP_W) - 1;
   localparam int NUM_W   = PHASE_BITS - 1;
   localparam int SPROD_W = MV_W + SAMP_W;
   localparam int TPROD_W = MV_W + NUM_W;
   localparam int Y_W     = SPROD_W + 1;
   localparam int Q_W     = MV_W + 1;
   localparam int NSTG    = 5;

   function automatic logic signed [OUT_W-1:0] level_mv(input logic [MV_W-1:0] base_mv,
                                                        input logic neg,
                                                        input logic [Q_W-1:0] delta);
      logic [OUT_W-1:0] b;
      logic [OUT_W-1:0] d;
      b = OUT_W'(base_mv);
      d = OUT_W'(delta);
      return neg ? $signed(b - d) : $signed(b + d);
   endfunction

   // quarter-wave ROM, constant contents, registered read
   logic [SAMP_W-1:0] rom_tbl [ROM_LEN];
   for (genvar gi = 0; gi < ROM_LEN; gi++) begin : g_rom
      assign rom_tbl[gi] = SAMP_W'(sine_entry(gi, LUT_ADDR_BITS, LUT_SAMPLE_BITS));
   end

   logic                    adv;
   logic [NSTG-1:0]         vld_ff, vld_in;
   logic [NSTG-1:0]         neg_ff, neg_in;
   logic                    rsp_valid_ff;

   logic [LUT_ADDR_BITS+1:0] top_bits;
   logic [1:0]               quad;
   logic [LUT_ADDR_BITS-1:0] off;
   logic [ROM_AW-1:0]        rom_addr;
   logic [PHASE_BITS-3:0]    m;
   logic [NUM_W-1:0]         num_in;

   logic [SAMP_W-1:0]  rom_q_ff;
   logic [NUM_W-1:0]   num1_ff;
   logic [SPROD_W-1:0] sprod2_ff, sprod_in;
   logic [TPROD_W-1:0] tprod2_ff, tprod_in;
   logic [Y_W-1:0]     y3_ff, y_in;
   logic [TPROD_W:0]   tsum;
   logic [Q_W-1:0]     tdelta3_ff, tdelta_in;
   logic [Y_W:0]       ysum;
   logic [Y_W-1:0]     y4_ff;
   logic [Q_W-1:0]     q0_4_ff, q0_in;
   logic [Q_W-1:0]     tdelta4_ff;
   logic [Y_W-1:0]     rem;
   logic [Q_W-1:0]     sdelta5_ff, sdelta_in;
   logic [Q_W-1:0]     tdelta5_ff;
   logic signed [OUT_W-1:0] sine_ff, sine_in;
   logic signed [OUT_W-1:0] tri_ff, tri_in;
   logic signed [OUT_W-1:0] sq_ff, sq_in;

   // whole pipe moves together; stalls only on a held result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign vld_in    = {vld_ff[NSTG-2:0], pop_valid};
   assign neg_in    = {neg_ff[NSTG-2:0], pop_phase[PHASE_BITS-1]};

   // stage 0: quadrant fold for ROM and triangle
   always_comb begin
      top_bits = pop_phase[PHASE_BITS-1 -: LUT_ADDR_BITS + 2];
      quad     = top_bits[LUT_ADDR_BITS+1 -: 2];
      off      = top_bits[LUT_ADDR_BITS-1:0];
      rom_addr = quad[0] ? {1'b1, {LUT_ADDR_BITS{1'b0}}} - {1'b0, off} : {1'b0, off};
      m        = pop_phase[PHASE_BITS-3:0];
      num_in   = quad[0] ? {1'b1, {(PHASE_BITS-2){1'b0}}} - {1'b0, m} : {1'b0, m};
   end

   // stage 2 multiplies, stage 3 rounding, stage 4 reciprocal estimate,
   // stage 5 one-step correction of the divide by SMAX
   always_comb begin
      sprod_in  = SPROD_W'(cfg.amplitude_mv) * SPROD_W'(rom_q_ff);
      tprod_in  = TPROD_W'(cfg.amplitude_mv) * TPROD_W'(num1_ff);
      y_in      = Y_W'(sprod2_ff) + Y_W'(SMAX / 2);
      tsum      = (TPROD_W + 1)'(tprod2_ff)
                + (TPROD_W + 1)'({1'b1, {(PHASE_BITS-3){1'b0}}});
      tdelta_in = tsum[PHASE_BITS-2 +: Q_W];
      ysum      = {1'b0, y3_ff} + (Y_W + 1)'(y3_ff >> SAMP_W);
      q0_in     = ysum[SAMP_W +: Q_W];
      rem       = y4_ff - (Y_W'(q0_4_ff) << SAMP_W) + Y_W'(q0_4_ff);
      sdelta_in = q0_4_ff + Q_W'(rem >= Y_W'(SMAX));
      sine_in   = level_mv(cfg.reference_mv, neg_ff[NSTG-1], sdelta5_ff);
      tri_in    = level_mv(cfg.reference_mv, neg_ff[NSTG-1], tdelta5_ff);
      sq_in     = level_mv(cfg.reference_mv, neg_ff[NSTG-1], Q_W'(cfg.amplitude_mv));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff     <= neg_in;
         rom_q_ff   <= rom_tbl[rom_addr];
         num1_ff    <= num_in;
         sprod2_ff  <= sprod_in;
         tprod2_ff  <= tprod_in;
         y3_ff      <= y_in;
         tdelta3_ff <= tdelta_in;
         y4_ff      <= y3_ff;
         q0_4_ff    <= q0_in;
         tdelta4_ff <= tdelta3_ff;
         sdelta5_ff <= sdelta_in;
         tdelta5_ff <= tdelta4_ff;
         sine_ff    <= sine_in;
         tri_ff     <= tri_in;
         sq_ff      <= sq_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sine_mv     = sine_ff;
   assign rsp_triangle_mv = tri_ff;
   assign rsp_square_mv   = sq_ff;

   `DSG_ASSERT_NEXT(a_stall_freezes_pipe, rsp_valid_ff && !rsp_ready, vld_ff == $past(vld_ff))

endmodule

// ----- hw/rtl/dds_sine_triangle_square_generator.sv -----
// Top level of the DDS sine / triangle / square generator.
// Depends on dsg_pkg, dsg_front, dsg_queue and dsg_back.
//
//   channel | dir | handshake             | word
//   --------+-----+-----------------------+---------------------------------------
//   req     | in  | req_valid / req_ready | req_tick
//   rsp     | out | rsp_valid / rsp_ready | rsp_sine_mv, rsp_triangle_mv, rsp_square_mv
//   csr     | in  | csr_valid / csr_ready | csr_index, csr_data
//
// One word per cycle sustained while rsp_ready stays high; a result follows its req word
// through queue register, ROM read, multiply, round, estimate, correct and output reg.
// Synchronous active-high reset clears phase, queue, pipe valids and the
// registers to their defaults; no clearing pass, the ROM is constant.
// rsp stalls freeze the back pipe; the 4-deep queue lets req keep flowing
// until it fills. csr_ready is always high.
//
// Phase accumulator lives in the front end so each tick depends only on the
// previous one; everything after the queue is a straight feed-forward pipe.

module dds_sine_triangle_square_generator #(
   parameter int PHASE_BITS      = dsg_pkg::PHASE_BITS_DEF,
   parameter int LUT_ADDR_BITS   = dsg_pkg::LUT_ADDR_BITS_DEF,
   parameter int LUT_SAMPLE_BITS = dsg_pkg::LUT_SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tick,
   // waveform words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dsg_pkg::OUT_W-1:0]    rsp_sine_mv,
   output logic signed [dsg_pkg::OUT_W-1:0]    rsp_triangle_mv,
   output logic signed [dsg_pkg::OUT_W-1:0]    rsp_square_mv,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dsg_pkg::STEP_W-1:0]          csr_data
);
   import dsg_pkg::*;

   dsg_cfg_type           cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   logic [PHASE_BITS-1:0] push_phase;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [PHASE_BITS-1:0] pop_phase;

   // register file; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_STEP: cfg_in.phase_step   = csr_data;
            CSR_AMPLITUDE:  cfg_in.amplitude_mv = csr_data[MV_W-1:0];
            CSR_REFERENCE:  cfg_in.reference_mv = csr_data[MV_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: phase accumulator, one update per accepted word with req_tick set
   dsg_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .phase_step (cfg_ff.phase_step),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_tick   (req_tick),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_phase (push_phase)
   );

   // decoupling queue of phase words
   dsg_queue #(
      .WIDTH (PHASE_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_phase),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_phase)
   );

   // back: ROM lookup, scaling, offset, output register
   dsg_back #(
      .PHASE_BITS      (PHASE_BITS),
      .LUT_ADDR_BITS   (LUT_ADDR_BITS),
      .LUT_SAMPLE_BITS (LUT_SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_phase       (pop_phase),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sine_mv     (rsp_sine_mv),
      .rsp_triangle_mv (rsp_triangle_mv),
      .rsp_square_mv   (rsp_square_mv)
   );

endmodule
